/* src/mcep_pkg.sv */
// ----------------------------------------------------------------------------
// mcep_pkg
// Shared types, codes and reset values for the motion-checked pulser.
// ----------------------------------------------------------------------------
package mcep_pkg;

   // default geometry of one averaging group and of one sample
   localparam int DEF_SAMPLES_PER_AVERAGE = 10;
   localparam int DEF_SAMPLE_BITS         = 13;

   // configuration port geometry
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // register widths, fixed by the register map
   localparam int THRESH_W = 13;
   localparam int DUTY_W   = 8;
   localparam int CHECKS_W = 16;

   // register reset values
   localparam logic [THRESH_W-1:0] RST_MOTION_THRESHOLD = 13'd64;
   localparam logic [DUTY_W-1:0]   RST_START_DUTY       = 8'd35;
   localparam logic [DUTY_W-1:0]   RST_DUTY_STEP        = 8'd15;
   localparam logic [DUTY_W-1:0]   RST_DUTY_LIMIT       = 8'd245;
   localparam logic [CHECKS_W-1:0] RST_CHECKS_PER_LEVEL = 16'd1000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MOTION_THRESHOLD = 3'd0,
      REG_START_DUTY       = 3'd1,
      REG_DUTY_STEP        = 3'd2,
      REG_DUTY_LIMIT       = 3'd3,
      REG_CHECKS_PER_LEVEL = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      CMD_START      = 2'd0,
      CMD_SAMPLE     = 2'd1,
      CMD_PULSE_DONE = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      PH_IDLE       = 2'd0,
      PH_BASELINE   = 2'd1,
      PH_WAIT_PULSE = 2'd2,
      PH_CHECKING   = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ST_BUSY      = 3'd0,
      ST_PULSE     = 3'd1,
      ST_MOTION    = 3'd2,
      ST_EXHAUSTED = 3'd3,
      ST_IGNORED   = 3'd4
   } status_type;

endpackage

/* src/motion_checked_escalating_pulser_unit.sv */
// ----------------------------------------------------------------------------
// motion_checked_escalating_pulser_unit
// Averages accelerometer groups, checks for motion and escalates pulse duty.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command word (start, sample, pulse done) with a
//   three-axis sample. Every accepted word yields exactly one rsp_* word:
//   busy, pulse request (with rsp_pulse_duty), motion detected, levels
//   exhausted or ignored.
//   csr_* writes the five registers (threshold, start duty, step, limit,
//   checks per level); write them only while no word is in flight.
// Throughput: one word per cycle unless a waiting result is stalled.
//   An accepted word is registered and held on rsp_* until taken. The
//   path from the input to the result register is one sum, one
//   constant-reciprocal multiply per axis and a compare.
// Reset (synchronous, active high): the run goes idle, the output register
//   empties and the registers return to their defaults.
// Stall: while a result waits and rsp_stall is high, req_stall is raised
//   and the held result does not change; when the result is taken, a new
//   word is accepted in that same cycle.
// ----------------------------------------------------------------------------
module motion_checked_escalating_pulser_unit
   import mcep_pkg::*;
#(
   parameter int SAMPLES_PER_AVERAGE = DEF_SAMPLES_PER_AVERAGE,
   parameter int SAMPLE_BITS         = DEF_SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_cmd,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_x,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_y,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_z,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_status,
   output logic [DUTY_W-1:0]             rsp_pulse_duty,
   // configuration port
   input  logic                          csr_write,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data
);

   // Group geometry. A group sum holds N samples without overflow.
   localparam int LOG_N   = $clog2(SAMPLES_PER_AVERAGE);
   localparam int CNT_W   = (LOG_N > 0) ? LOG_N : 1;
   localparam int SUM_W   = SAMPLE_BITS + LOG_N;
   // Exact truncating division by N: floor(m * ceil(2^S / N) / 2^S) is exact
   // for every m below 2^SUM_W when S = SUM_W + ceil(log2 N).
   localparam int SHIFT   = SUM_W + LOG_N;
   localparam int RECIP_W = SUM_W + 2;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam longint unsigned RECIP_VAL =
      ((64'd1 << SHIFT) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
   localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(SAMPLES_PER_AVERAGE - 1);
   // Compare width for |base - avg| against the threshold
   localparam int DIFF_W = SAMPLE_BITS + 1;
   localparam int CMP_W  = (DIFF_W > THRESH_W) ? DIFF_W : THRESH_W;

   // Signed sum divided by N, truncated toward zero.
   function automatic logic signed [SAMPLE_BITS-1:0] group_avg(
      input logic signed [SUM_W-1:0] s
   );
      logic [SUM_W-1:0]  mag;
      logic [PROD_W-1:0] prod;
      logic [SUM_W-1:0]  quo;
      mag  = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
      prod = PROD_W'(mag) * PROD_W'(RECIP);
      quo  = SUM_W'(prod >> SHIFT);
      return s[SUM_W-1] ? SAMPLE_BITS'(-quo) : SAMPLE_BITS'(quo);
   endfunction

   // |base - avg| above the threshold
   function automatic logic axis_moved(
      input logic signed [SAMPLE_BITS-1:0] base,
      input logic signed [SAMPLE_BITS-1:0] avg,
      input logic [THRESH_W-1:0]           thresh
   );
      logic signed [DIFF_W-1:0] diff;
      logic [DIFF_W-1:0]        mag;
      diff = DIFF_W'(base) - DIFF_W'(avg);
      mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      return CMP_W'(mag) > CMP_W'(thresh);
   endfunction

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [THRESH_W-1:0] motion_threshold_ff;
   logic [DUTY_W-1:0]   start_duty_ff;
   logic [DUTY_W-1:0]   duty_step_ff;
   logic [DUTY_W-1:0]   duty_limit_ff;
   logic [CHECKS_W-1:0] checks_per_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         motion_threshold_ff <= RST_MOTION_THRESHOLD;
         start_duty_ff       <= RST_START_DUTY;
         duty_step_ff        <= RST_DUTY_STEP;
         duty_limit_ff       <= RST_DUTY_LIMIT;
         checks_per_level_ff <= RST_CHECKS_PER_LEVEL;
      end else if (csr_write) begin
         case (csr_index)
            REG_MOTION_THRESHOLD: motion_threshold_ff <= csr_data[THRESH_W-1:0];
            REG_START_DUTY:       start_duty_ff       <= csr_data[DUTY_W-1:0];
            REG_DUTY_STEP:        duty_step_ff        <= csr_data[DUTY_W-1:0];
            REG_DUTY_LIMIT:       duty_limit_ff       <= csr_data[DUTY_W-1:0];
            REG_CHECKS_PER_LEVEL: checks_per_level_ff <= csr_data[CHECKS_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Run state
   // ------------------------------------------------------------------------
   phase_type                     phase_ff, phase_in;
   logic [CNT_W-1:0]              group_count_ff, group_count_in;
   logic signed [SUM_W-1:0]       sum_x_ff, sum_y_ff, sum_z_ff;
   logic signed [SUM_W-1:0]       sum_x_in, sum_y_in, sum_z_in;
   logic signed [SAMPLE_BITS-1:0] base_x_ff, base_y_ff, base_z_ff;
   logic signed [SAMPLE_BITS-1:0] base_x_in, base_y_in, base_z_in;
   logic [DUTY_W-1:0]             duty_level_ff, duty_level_in;
   logic [CHECKS_W-1:0]           check_count_ff, check_count_in;

   // output register
   logic              rsp_valid_ff;
   status_type        status_ff, status_in;
   logic [DUTY_W-1:0] pulse_duty_ff, pulse_duty_in;

   logic    req_accept;
   cmd_type cmd;

   // Hold new words back only while a result waits and is stalled.
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign cmd        = cmd_type'(req_cmd);

   // Datapath: add this sample, divide the completed group
   logic signed [SUM_W-1:0]       new_sum_x, new_sum_y, new_sum_z;
   logic signed [SAMPLE_BITS-1:0] avg_x, avg_y, avg_z;
   logic                          group_done, moved, start_exhausted;
   logic [CHECKS_W:0]             check_next;
   logic                          level_done;
   logic [DUTY_W:0]               duty_next;
   logic                          step_exhausted;
   logic                          in_group_phase;

   assign new_sum_x = sum_x_ff + SUM_W'(req_accel_x);
   assign new_sum_y = sum_y_ff + SUM_W'(req_accel_y);
   assign new_sum_z = sum_z_ff + SUM_W'(req_accel_z);
   assign avg_x     = group_avg(new_sum_x);
   assign avg_y     = group_avg(new_sum_y);
   assign avg_z     = group_avg(new_sum_z);

   assign group_done = (group_count_ff == LAST_COUNT);
   assign moved      = axis_moved(base_x_ff, avg_x, motion_threshold_ff) |
                       axis_moved(base_y_ff, avg_y, motion_threshold_ff) |
                       axis_moved(base_z_ff, avg_z, motion_threshold_ff);
   assign start_exhausted = (start_duty_ff >= duty_limit_ff);

   // A zero check count escalates after every group, like a count of one.
   assign check_next = (CHECKS_W + 1)'(check_count_ff) + (CHECKS_W + 1)'(1);
   assign level_done = (check_next >= (CHECKS_W + 1)'(checks_per_level_ff));
   assign duty_next  = (DUTY_W + 1)'(duty_level_ff) + (DUTY_W + 1)'(duty_step_ff);
   // Past full scale or at or above the limit, the levels are used up.
   assign step_exhausted = duty_next[DUTY_W] |
                           (duty_next[DUTY_W-1:0] >= duty_limit_ff);

   assign in_group_phase = (phase_ff inside {PH_BASELINE, PH_CHECKING});

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      case (cmd)
         CMD_START: begin
            phase_in = PH_BASELINE;
         end
         CMD_SAMPLE: begin
            if (group_done) begin
               case (phase_ff)
                  PH_BASELINE: begin
                     phase_in = start_exhausted ? PH_IDLE : PH_WAIT_PULSE;
                  end
                  PH_CHECKING: begin
                     if (moved) begin
                        phase_in = PH_IDLE;
                     end else if (level_done) begin
                        phase_in = step_exhausted ? PH_IDLE : PH_WAIT_PULSE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         CMD_PULSE_DONE: begin
            if (phase_ff == PH_WAIT_PULSE) begin
               phase_in = PH_CHECKING;
            end
         end
         default: ;
      endcase
   end

   // Group, level and result updates
   always_comb begin
      group_count_in = group_count_ff;
      sum_x_in       = sum_x_ff;
      sum_y_in       = sum_y_ff;
      sum_z_in       = sum_z_ff;
      base_x_in      = base_x_ff;
      base_y_in      = base_y_ff;
      base_z_in      = base_z_ff;
      duty_level_in  = duty_level_ff;
      check_count_in = check_count_ff;
      status_in      = ST_IGNORED;
      pulse_duty_in  = '0;
      case (cmd)
         CMD_START: begin
            group_count_in = '0;
            sum_x_in       = '0;
            sum_y_in       = '0;
            sum_z_in       = '0;
            check_count_in = '0;
            duty_level_in  = start_duty_ff;
            status_in      = ST_BUSY;
         end
         CMD_SAMPLE: begin
            if (in_group_phase) begin
               status_in = ST_BUSY;
               if (!group_done) begin
                  // accumulate into the open group
                  group_count_in = group_count_ff + CNT_W'(1);
                  sum_x_in       = new_sum_x;
                  sum_y_in       = new_sum_y;
                  sum_z_in       = new_sum_z;
               end else begin
                  // group complete: start a fresh one
                  group_count_in = '0;
                  sum_x_in       = '0;
                  sum_y_in       = '0;
                  sum_z_in       = '0;
                  if (phase_ff == PH_BASELINE) begin
                     base_x_in     = avg_x;
                     base_y_in     = avg_y;
                     base_z_in     = avg_z;
                     duty_level_in = start_duty_ff;
                     if (start_exhausted) begin
                        status_in = ST_EXHAUSTED;
                     end else begin
                        status_in     = ST_PULSE;
                        pulse_duty_in = start_duty_ff;
                     end
                  end else if (moved) begin
                     status_in = ST_MOTION;
                  end else if (level_done) begin
                     check_count_in = '0;
                     if (step_exhausted) begin
                        status_in = ST_EXHAUSTED;
                     end else begin
                        duty_level_in = duty_next[DUTY_W-1:0];
                        status_in     = ST_PULSE;
                        pulse_duty_in = duty_next[DUTY_W-1:0];
                     end
                  end else begin
                     check_count_in = check_next[CHECKS_W-1:0];
                  end
               end
            end
         end
         CMD_PULSE_DONE: begin
            if (phase_ff == PH_WAIT_PULSE) begin
               group_count_in = '0;
               sum_x_in       = '0;
               sum_y_in       = '0;
               sum_z_in       = '0;
               check_count_in = '0;
               status_in      = ST_BUSY;
            end
         end
         default: ;
      endcase
   end

   // Advance run state on every accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         group_count_ff <= '0;
         sum_x_ff       <= '0;
         sum_y_ff       <= '0;
         sum_z_ff       <= '0;
         base_x_ff      <= '0;
         base_y_ff      <= '0;
         base_z_ff      <= '0;
         duty_level_ff  <= '0;
         check_count_ff <= '0;
      end else if (req_accept) begin
         phase_ff       <= phase_in;
         group_count_ff <= group_count_in;
         sum_x_ff       <= sum_x_in;
         sum_y_ff       <= sum_y_in;
         sum_z_ff       <= sum_z_in;
         base_x_ff      <= base_x_in;
         base_y_ff      <= base_y_in;
         base_z_ff      <= base_z_in;
         duty_level_ff  <= duty_level_in;
         check_count_ff <= check_count_in;
      end
   end

   // Output register: load on accept, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         status_ff     <= status_in;
         pulse_duty_ff <= pulse_duty_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_pulse_duty = pulse_duty_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("request stalled with an empty output register");

   a_duty_only_on_pulse : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff != ST_PULSE) |-> (pulse_duty_ff == '0))
      else $error("pulse duty set on a non-pulse result");

   a_end_goes_idle : assert property (@(posedge clock) disable iff (reset)
      (req_accept && (status_in == ST_MOTION || status_in == ST_EXHAUSTED))
      |=> (phase_ff == PH_IDLE))
      else $error("run did not end after a final result");

   a_pulse_waits : assert property (@(posedge clock) disable iff (reset)
      (req_accept && status_in == ST_PULSE)
      |=> (phase_ff == PH_WAIT_PULSE && group_count_ff == '0))
      else $error("pulse request without waiting for pulse done");

   a_group_in_range : assert property (@(posedge clock) disable iff (reset)
      group_count_ff <= LAST_COUNT)
      else $error("group count beyond group size");

endmodule

/* tb/tb_motion_checked_escalating_pulser_unit.sv */
// ----------------------------------------------------------------------------
// tb_motion_checked_escalating_pulser_unit
// Self-checking bench for the motion-checked escalating pulser. A behavioral
// copy of the pulser runs beside the unit and predicts every response word.
// A short hand-built run opens the test. Whole runs with random sample data
// follow under a series of register settings, the extremes among them, with
// random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_motion_checked_escalating_pulser_unit;
   import mcep_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLES     = DEF_SAMPLES_PER_AVERAGE;
   localparam int SAMPLE_W    = DEF_SAMPLE_BITS;
   localparam int SAMPLE_MAX  = (1 << (SAMPLE_W - 1)) - 1;
   localparam int SAMPLE_MIN  = -(1 << (SAMPLE_W - 1));
   localparam int DUTY_MAX    = (1 << DUTY_W) - 1;
   localparam int THRESH_MAX  = (1 << THRESH_W) - 1;
   localparam int CHECKS_MAX  = (1 << CHECKS_W) - 1;
   localparam int MAX_WAIT    = 18;
   localparam int CYCLE_LIMIT = 500000;

   // the command code that the package leaves unnamed; the unit ignores it
   localparam logic [1:0] CMD_RESERVED = 2'd3;

   typedef struct {
      logic [1:0]                 cmd;
      logic signed [SAMPLE_W-1:0] ax;
      logic signed [SAMPLE_W-1:0] ay;
      logic signed [SAMPLE_W-1:0] az;
   } cmd_word_type;

   typedef struct {
      status_type        status;
      logic [DUTY_W-1:0] duty;
   } reply_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [1:0]                 req_cmd;
   logic signed [SAMPLE_W-1:0] req_accel_x;
   logic signed [SAMPLE_W-1:0] req_accel_y;
   logic signed [SAMPLE_W-1:0] req_accel_z;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [2:0]                 rsp_status;
   logic [DUTY_W-1:0]          rsp_pulse_duty;
   logic                       csr_write;
   logic [CSR_INDEX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]      csr_data;

   motion_checked_escalating_pulser_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_accel_x    (req_accel_x),
      .req_accel_y    (req_accel_y),
      .req_accel_z    (req_accel_z),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_pulse_duty (rsp_pulse_duty),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   // -------------------------------------------------------------------------
   // Predicted state of the pulser: register copies and run state
   // -------------------------------------------------------------------------
   logic [THRESH_W-1:0] thr_cfg;
   logic [DUTY_W-1:0]   start_cfg;
   logic [DUTY_W-1:0]   step_cfg;
   logic [DUTY_W-1:0]   limit_cfg;
   logic [CHECKS_W-1:0] checks_cfg;

   phase_type         run_phase;
   int                group_fill;
   int                acc_x, acc_y, acc_z;
   int                base_x, base_y, base_z;
   logic [DUTY_W-1:0] duty_now;
   int                checks_done;

   // response words still owed by the unit, oldest first
   reply_type pending_replies[$];

   int  mismatches  = 0;
   int  cycle_count = 0;
   int  stall_left  = 0;
   // clear to run both channels at full rate for a stretch
   bit  idling      = 1'b1;

   // -------------------------------------------------------------------------
   // Clock and watchdog
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Predictor
   // -------------------------------------------------------------------------
   function automatic void reset_model();
      thr_cfg     = RST_MOTION_THRESHOLD;
      start_cfg   = RST_START_DUTY;
      step_cfg    = RST_DUTY_STEP;
      limit_cfg   = RST_DUTY_LIMIT;
      checks_cfg  = RST_CHECKS_PER_LEVEL;
      run_phase   = PH_IDLE;
      group_fill  = 0;
      acc_x       = 0;
      acc_y       = 0;
      acc_z       = 0;
      base_x      = 0;
      base_y      = 0;
      base_z      = 0;
      duty_now    = '0;
      checks_done = 0;
   endfunction

   function automatic void clear_group();
      group_fill = 0;
      acc_x      = 0;
      acc_y      = 0;
      acc_z      = 0;
   endfunction

   // true when the averaged axis strays from its baseline by more than the
   // threshold; the signed divide truncates toward zero, as the unit must
   function automatic logic axis_moved(int base, int sum);
      int d;
      d = base - sum / SAMPLES;
      if (d < 0) d = -d;
      return d > int'(thr_cfg);
   endfunction

   function automatic reply_type advance_pulser(cmd_word_type w);
      reply_type r;
      logic      moved;
      int        next_duty;
      r.status = ST_IGNORED;
      r.duty   = '0;
      if (w.cmd == CMD_START) begin
         // a start restarts the run from the baseline, busy or not
         run_phase   = PH_BASELINE;
         clear_group();
         checks_done = 0;
         duty_now    = start_cfg;
         r.status    = ST_BUSY;
      end else if (w.cmd == CMD_SAMPLE &&
                   (run_phase == PH_BASELINE || run_phase == PH_CHECKING)) begin
         r.status = ST_BUSY;
         acc_x += w.ax;
         acc_y += w.ay;
         acc_z += w.az;
         group_fill++;
         if (group_fill >= SAMPLES) begin
            if (run_phase == PH_BASELINE) begin
               base_x   = acc_x / SAMPLES;
               base_y   = acc_y / SAMPLES;
               base_z   = acc_z / SAMPLES;
               clear_group();
               duty_now = start_cfg;
               if (duty_now >= limit_cfg) begin
                  run_phase = PH_IDLE;
                  r.status  = ST_EXHAUSTED;
               end else begin
                  run_phase = PH_WAIT_PULSE;
                  r.status  = ST_PULSE;
                  r.duty    = duty_now;
               end
            end else begin
               moved = axis_moved(base_x, acc_x) || axis_moved(base_y, acc_y) ||
                       axis_moved(base_z, acc_z);
               clear_group();
               if (moved) begin
                  run_phase = PH_IDLE;
                  r.status  = ST_MOTION;
               end else begin
                  checks_done++;
                  // a zero count acts as one check per level
                  if (checks_done >= int'(checks_cfg)) begin
                     next_duty   = int'(duty_now) + int'(step_cfg);
                     checks_done = 0;
                     if (next_duty > DUTY_MAX || next_duty >= int'(limit_cfg)) begin
                        run_phase = PH_IDLE;
                        r.status  = ST_EXHAUSTED;
                     end else begin
                        duty_now  = next_duty[DUTY_W-1:0];
                        run_phase = PH_WAIT_PULSE;
                        r.status  = ST_PULSE;
                        r.duty    = duty_now;
                     end
                  end
               end
            end
         end
      end else if (w.cmd == CMD_PULSE_DONE && run_phase == PH_WAIT_PULSE) begin
         run_phase   = PH_CHECKING;
         clear_group();
         checks_done = 0;
         r.status    = ST_BUSY;
      end
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Helpers for building words
   // -------------------------------------------------------------------------
   function automatic int pick_wait();
      if (!idling) return 0;
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return $urandom_range(0, 3);
         default: return $urandom_range(0, MAX_WAIT);
      endcase
   endfunction

   function automatic int clamp_sample(int v);
      if (v > SAMPLE_MAX) return SAMPLE_MAX;
      if (v < SAMPLE_MIN) return SAMPLE_MIN;
      return v;
   endfunction

   function automatic int jitter_of(int amp);
      return int'($urandom_range(0, 2 * amp)) - amp;
   endfunction

   function automatic cmd_word_type make_word(logic [1:0] cmd, int x, int y, int z);
      cmd_word_type w;
      w.cmd = cmd;
      w.ax  = x[SAMPLE_W-1:0];
      w.ay  = y[SAMPLE_W-1:0];
      w.az  = z[SAMPLE_W-1:0];
      return w;
   endfunction

   // -------------------------------------------------------------------------
   // Request side: send one word, record its predicted response
   // -------------------------------------------------------------------------
   task automatic send_word(input cmd_word_type w);
      int gap;
      gap = pick_wait();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_cmd     = w.cmd;
      req_accel_x = w.ax;
      req_accel_y = w.ay;
      req_accel_z = w.az;
      // hold the word until an edge takes it
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_replies.push_back(advance_pulser(w));
      @(negedge clock);
   endtask

   // drop the request, let every owed response arrive, end on a falling edge
   task automatic drain_replies();
      req_valid = 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Register writes; bits above a register's width carry random junk
   // -------------------------------------------------------------------------
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input int unsigned value);
      logic [CSR_DATA_W-1:0] data;
      data = CSR_DATA_W'($urandom);
      case (idx)
         REG_MOTION_THRESHOLD: data[THRESH_W-1:0] = value[THRESH_W-1:0];
         REG_START_DUTY,
         REG_DUTY_STEP,
         REG_DUTY_LIMIT:       data[DUTY_W-1:0] = value[DUTY_W-1:0];
         REG_CHECKS_PER_LEVEL: data = value[CHECKS_W-1:0];
         default:              ;
      endcase
      csr_write = 1'b1;
      csr_index = idx;
      csr_data  = data;
      @(posedge clock);
      case (idx)
         REG_MOTION_THRESHOLD: thr_cfg    = data[THRESH_W-1:0];
         REG_START_DUTY:       start_cfg  = data[DUTY_W-1:0];
         REG_DUTY_STEP:        step_cfg   = data[DUTY_W-1:0];
         REG_DUTY_LIMIT:       limit_cfg  = data[DUTY_W-1:0];
         REG_CHECKS_PER_LEVEL: checks_cfg = data[CHECKS_W-1:0];
         default:              ;
      endcase
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   task automatic program_regs(input int unsigned thr, input int unsigned start,
                               input int unsigned step, input int unsigned limit,
                               input int unsigned checks);
      drain_replies();
      write_reg(REG_MOTION_THRESHOLD, thr);
      write_reg(REG_START_DUTY, start);
      write_reg(REG_DUTY_STEP, step);
      write_reg(REG_DUTY_LIMIT, limit);
      write_reg(REG_CHECKS_PER_LEVEL, checks);
   endtask

   // -------------------------------------------------------------------------
   // Random runs, steered by the predicted phase so that most words are
   // well formed: start, ten baseline samples, pulse done, check groups.
   // About one word in twelve is noise: any command, any sample value.
   // Each check group is quiet, sits exactly on the threshold, steps one
   // past it on one axis, or is wild.
   // -------------------------------------------------------------------------
   task automatic drive_runs(input int budget, input int motion_pct);
      cmd_word_type w;
      int center[3];
      int offset[3];
      int amp;
      int base_amp;
      int roll;
      int axis;
      int thr;
      for (int n = 0; n < budget; n++) begin
         if (n % 60 == 0) idling = ($urandom_range(0, 3) != 0);
         thr = int'(thr_cfg);
         if ($urandom_range(0, 99) < 8) begin
            w = make_word(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
         end else begin
            case (run_phase)
               PH_IDLE: begin
                  for (int a = 0; a < 3; a++)
                     center[a] = ($urandom_range(0, 7) == 0) ?
                                 ($urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN) :
                                 int'($urandom_range(0, 6000)) - 3000;
                  base_amp = $urandom_range(0, 40);
                  w = make_word(CMD_START, 0, 0, 0);
               end
               PH_BASELINE: begin
                  w = make_word(CMD_SAMPLE,
                                clamp_sample(center[0] + jitter_of(base_amp)),
                                clamp_sample(center[1] + jitter_of(base_amp)),
                                clamp_sample(center[2] + jitter_of(base_amp)));
               end
               PH_WAIT_PULSE: begin
                  w = make_word(CMD_PULSE_DONE, $urandom, $urandom, $urandom);
               end
               default: begin
                  if (group_fill == 0) begin
                     roll = $urandom_range(0, 99);
                     for (int a = 0; a < 3; a++) offset[a] = 0;
                     amp = 0;
                     if (roll < motion_pct) begin
                        axis = $urandom_range(0, 2);
                        offset[axis] = $urandom_range(0, 1) ? thr + 1 : -(thr + 1);
                     end else if (roll < motion_pct + 8) begin
                        for (int a = 0; a < 3; a++)
                           offset[a] = $urandom_range(0, 1) ? thr : -thr;
                     end else if (roll < motion_pct + 11) begin
                        amp = SAMPLE_MAX;
                     end else begin
                        amp = thr / 3;
                     end
                  end
                  w = make_word(CMD_SAMPLE,
                                clamp_sample(base_x + offset[0] + jitter_of(amp)),
                                clamp_sample(base_y + offset[1] + jitter_of(amp)),
                                clamp_sample(base_z + offset[2] + jitter_of(amp)));
               end
            endcase
         end
         send_word(w);
      end
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Hand-built run under the reset settings: ignored words of every kind,
   // a restart while busy, full-scale samples, a baseline whose averages
   // truncate toward zero, and a check group that sits on the threshold on
   // one axis and steps one past it on another.
   task automatic test_directed_run();
      idling = 1'b1;
      send_word(make_word(CMD_RESERVED, SAMPLE_MAX, SAMPLE_MIN, 0));
      send_word(make_word(CMD_SAMPLE, SAMPLE_MAX, SAMPLE_MIN, 0));
      send_word(make_word(CMD_START, 0, 0, 0));
      send_word(make_word(CMD_SAMPLE, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX));
      send_word(make_word(CMD_SAMPLE, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN));
      send_word(make_word(CMD_START, 0, 0, 0));
      // x averages -0.5, z averages -1.9: both must truncate toward zero
      for (int i = 0; i < SAMPLES; i++)
         send_word(make_word(CMD_SAMPLE, (i % 2) ? SAMPLE_MIN : SAMPLE_MAX, SAMPLE_MIN,
                             (i == 0) ? -19 : 0));
      send_word(make_word(CMD_SAMPLE, 0, 0, 0));
      send_word(make_word(CMD_PULSE_DONE, 0, 0, 0));
      send_word(make_word(CMD_PULSE_DONE, 0, 0, 0));
      for (int i = 0; i < SAMPLES; i++)
         send_word(make_word(CMD_SAMPLE, int'(thr_cfg), SAMPLE_MIN, base_z + thr_cfg + 1));
   endtask

   // Short levels so that the duty climbs until it meets the limit.
   task automatic test_duty_escalation();
      program_regs($urandom_range(20, 200), $urandom_range(0, 60),
                   $urandom_range(1, 40), DUTY_MAX, $urandom_range(1, 3));
      drive_runs(175, 3);
      program_regs($urandom_range(20, 200), $urandom_range(0, 60),
                   $urandom_range(1, 40), $urandom_range(100, 200), $urandom_range(1, 3));
      drive_runs(175, 3);
   endtask

   // Large start and step: the next duty runs past the top of its range.
   task automatic test_duty_overflow();
      program_regs($urandom_range(30, 100), $urandom_range(200, 250),
                   $urandom_range(200, DUTY_MAX), DUTY_MAX, $urandom_range(1, 2));
      drive_runs(150, 4);
   endtask

   // Zero step repeats the same duty; zero checks act as one; a zero
   // threshold flags any offset at all.
   task automatic test_zero_step_and_checks();
      program_regs(0, 0, 0, DUTY_MAX, 0);
      drive_runs(150, 5);
   endtask

   // Start duty at or above the limit ends each run at the baseline.
   task automatic test_start_at_limit();
      program_regs(THRESH_MAX, DUTY_MAX, DUTY_MAX, 0, CHECKS_MAX);
      drive_runs(50, 5);
      program_regs(THRESH_MAX, 100, 7, 100, 1);
      drive_runs(50, 5);
   endtask

   // Long levels: runs end on motion, or never with the largest threshold.
   task automatic test_threshold_edges();
      program_regs($urandom_range(1, 30), int'(RST_START_DUTY), int'(RST_DUTY_STEP),
                   int'(RST_DUTY_LIMIT), CHECKS_MAX);
      drive_runs(150, 25);
      program_regs(THRESH_MAX, int'(RST_START_DUTY), int'(RST_DUTY_STEP),
                   int'(RST_DUTY_LIMIT), CHECKS_MAX);
      drive_runs(100, 25);
   endtask

   // Fully random settings; also poke an index past the register map.
   task automatic test_random_settings();
      repeat (4) begin
         program_regs(($urandom_range(0, 3) == 0) ? $urandom_range(0, THRESH_MAX) :
                                                    $urandom_range(0, 300),
                      $urandom_range(0, DUTY_MAX), $urandom_range(0, DUTY_MAX),
                      $urandom_range(0, DUTY_MAX),
                      ($urandom_range(0, 7) == 0) ? $urandom_range(0, CHECKS_MAX) :
                                                    $urandom_range(0, 5));
         write_reg(CSR_INDEX_W'(REG_CHECKS_PER_LEVEL + 1 + $urandom_range(0, 2)),
                   $urandom);
         drive_runs(150, 5);
      end
   endtask

   // Back to the reset values.
   task automatic test_default_settings();
      program_regs(int'(RST_MOTION_THRESHOLD), int'(RST_START_DUTY), int'(RST_DUTY_STEP),
                   int'(RST_DUTY_LIMIT), int'(RST_CHECKS_PER_LEVEL));
      drive_runs(150, 10);
   endtask

   // -------------------------------------------------------------------------
   // Response side: stall for a drawn number of cycles, then take the word
   // -------------------------------------------------------------------------
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_stall = 1'b1;
            stall_left--;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   // compare each taken word with the oldest prediction
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_replies.size() == 0) begin
            $display("%0t: unexpected word, status %0d duty %0d", $time,
                     rsp_status, rsp_pulse_duty);
            mismatches++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d got %0d", $time, want.status, rsp_status);
               mismatches++;
            end
            if (rsp_pulse_duty !== want.duty) begin
               $display("%0t: pulse_duty expected %0d got %0d", $time, want.duty,
                        rsp_pulse_duty);
               mismatches++;
            end
         end
         stall_left = pick_wait();
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_cmd     = CMD_START;
      req_accel_x = '0;
      req_accel_y = '0;
      req_accel_z = '0;
      csr_write   = 1'b0;
      csr_index   = REG_MOTION_THRESHOLD;
      csr_data    = '0;
      reset_model();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_run();
      test_duty_escalation();
      test_duty_overflow();
      test_zero_step_and_checks();
      test_start_at_limit();
      test_threshold_edges();
      test_random_settings();
      test_default_settings();

      // wait out every owed word, then go on waiting to catch strays
      drain_replies();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
